### src/chti_pkg.sv
// Shared types and constants for the chained hash table insert block.
package chti_pkg;
	localparam int unsigned BucketsDefault = 8;
	localparam int unsigned RecordsDefault = 256;
	localparam int unsigned KeyW = 31;
	localparam int unsigned PayW = 64;
	localparam int unsigned CntW = 4;
	localparam logic [CntW-1:0] BucketCountReset = 4'd7;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_PRELOAD = 2'd1,
		OP_HEAD    = 2'd2,
		OP_NOP     = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_FULL      = 2'd2,
		ST_LOADED    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_READ,
		S_CHECK,
		S_LINK,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic            go;
		logic [KeyW-1:0] key;
		logic [CntW-1:0] modulus;
	} hash_req_t;

	typedef struct packed {
		logic            done;
		logic [CntW-1:0] rem;
	} hash_rsp_t;
endpackage

### src/chti_hash.sv
// Bit-serial key modulo bucket count, one key bit per cycle.
module chti_hash (
	input  logic               clk,
	input  logic               arst_n,
	input  chti_pkg::hash_req_t req,
	output chti_pkg::hash_rsp_t rsp
);
	import chti_pkg::*;

	logic [KeyW-1:0] key_q;
	logic [CntW-1:0] mod_q;
	logic [CntW-1:0] rem_q;
	logic [4:0]      cnt_q;
	logic            run_q;
	logic            done_q;
	logic [CntW:0]   trial;

	always_comb begin
		trial = {rem_q, key_q[KeyW-1]};
		if (trial >= {1'b0, mod_q}) begin
			trial = trial - {1'b0, mod_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= 5'(KeyW - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			key_q <= req.key;
			mod_q <= req.modulus;
			rem_q <= '0;
		end else if (run_q) begin
			key_q <= {key_q[KeyW-2:0], 1'b0};
			rem_q <= trial[CntW-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;
endmodule

### src/chained_hash_table_insert.sv
// Top level: chained hash table insert over a record pool in one synchronous memory.
// Steps: preload and head write pass through S_EXEC before the strobe; insert hashes
// the key in S_HASH, then reads and checks each chain record in S_READ and S_CHECK,
// and links an append in S_LINK; the bit-serial hash and single-port memory set these steps.
// One word at a time; busy stays high until the result is issued; results cannot stall.
// Reset clears the bucket heads to empty, the pool end to zero and bucket_count to 7.
module chained_hash_table_insert #(
	parameter int unsigned BUCKETS = chti_pkg::BucketsDefault,
	parameter int unsigned RECORDS = chti_pkg::RecordsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [30:0] key,
	input  logic [63:0] payload,
	input  logic [7:0]  slot_index,
	input  logic [2:0]  bucket_index,
	input  logic [8:0]  link_index,
	input  logic        occupied_flag,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	output logic        strobe,
	output logic [7:0]  position,
	output logic [1:0]  status
);
	import chti_pkg::*;

	localparam int unsigned AW = $clog2(RECORDS);
	localparam int unsigned PW = AW + 1;
	localparam int unsigned HW = $clog2(BUCKETS);
	localparam logic [PW-1:0] NONE = PW'(RECORDS);

	typedef struct packed {
		logic            used;
		logic [PW-1:0]   link;
		logic [KeyW-1:0] key;
		logic [PayW-1:0] pay;
	} rec_t;

	rec_t            mem [RECORDS];
	rec_t            rd_q;
	logic [PW-1:0]   heads_q [BUCKETS];
	logic [PW-1:0]   count_q;
	logic [CntW-1:0] bcnt_q;
	state_t          state_q, state_d;

	logic [1:0]      op_q;
	logic [KeyW-1:0] key_q;
	logic [PayW-1:0] pay_q;
	logic [7:0]      slot_q;
	logic [2:0]      bkt_q;
	logic [8:0]      link_q;
	logic            occ_q;
	logic [PW-1:0]   cur_q;
	logic [PW-1:0]   steps_q;
	logic [PW-1:0]   newpos_q;

	logic            strobe_q;
	logic [7:0]      pos_q;
	logic [1:0]      stat_q;

	hash_req_t       hreq;
	hash_rsp_t       hrsp;
	logic [CntW-1:0] modulus;
	logic            accept;
	logic [PW-1:0]   link_norm;
	logic            slot_ok;
	logic            bkt_ok;
	logic [HW-1:0]   hidx;
	logic [PW-1:0]   head;

	logic            we;
	logic [AW-1:0]   waddr;
	rec_t            wdata;
	logic            rd_en;
	logic            res_set;
	logic [PW-1:0]   res_pos;
	status_t         res_st;
	logic            head_we;
	logic [HW-1:0]   head_idx;
	logic [PW-1:0]   head_val;
	logic            count_inc;
	logic            walk_next;
	logic            app_walk;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		if (bcnt_q == '0) begin
			modulus = CntW'(1);
		end else if (32'(bcnt_q) > BUCKETS) begin
			modulus = CntW'(BUCKETS);
		end else begin
			modulus = bcnt_q;
		end
	end

	assign hreq.go      = accept && (opcode == OP_INSERT);
	assign hreq.key     = key;
	assign hreq.modulus = modulus;

	chti_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.rsp    (hrsp)
	);

	assign link_norm = (32'(link_q) >= RECORDS) ? NONE : PW'(link_q);
	assign slot_ok   = (32'(slot_q) < RECORDS);
	assign bkt_ok    = (32'(bkt_q) < BUCKETS);
	assign hidx      = HW'(hrsp.rem);
	assign head      = heads_q[hidx];

	always_comb begin
		state_d   = state_q;
		we        = 1'b0;
		waddr     = count_q[AW-1:0];
		wdata     = '{used: 1'b1, link: NONE, key: key_q, pay: pay_q};
		rd_en     = 1'b0;
		res_set   = 1'b0;
		res_pos   = '0;
		res_st    = ST_LOADED;
		head_we   = 1'b0;
		head_idx  = hidx;
		head_val  = count_q;
		count_inc = 1'b0;
		walk_next = 1'b0;
		app_walk  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (opcode == OP_INSERT) ? S_HASH : S_EXEC;
				end
			end
			S_EXEC: begin
				res_set = 1'b1;
				state_d = S_IDLE;
				if (op_q == OP_PRELOAD) begin
					res_pos = PW'(slot_q);
					if (slot_ok) begin
						we    = 1'b1;
						waddr = AW'(slot_q);
						wdata = '{used: occ_q, link: link_norm, key: key_q, pay: pay_q};
					end
				end else if (op_q == OP_HEAD && bkt_ok) begin
					head_we  = 1'b1;
					head_idx = HW'(bkt_q);
					head_val = link_norm;
				end
			end
			S_HASH: begin
				if (hrsp.done) begin
					if (head == NONE) begin
						res_set = 1'b1;
						state_d = S_IDLE;
						if (count_q >= NONE) begin
							res_st = ST_FULL;
						end else begin
							we        = 1'b1;
							head_we   = 1'b1;
							count_inc = 1'b1;
							res_pos   = count_q;
							res_st    = ST_INSERTED;
						end
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				rd_en   = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (steps_q == NONE) begin
					res_set = 1'b1;
					res_st  = ST_FULL;
					state_d = S_IDLE;
				end else if (rd_q.key == key_q) begin
					res_set = 1'b1;
					res_st  = ST_DUPLICATE;
					state_d = S_IDLE;
				end else if (!rd_q.used) begin
					we      = 1'b1;
					waddr   = cur_q[AW-1:0];
					wdata   = '{used: 1'b1, link: rd_q.link, key: key_q, pay: pay_q};
					res_set = 1'b1;
					res_pos = cur_q;
					res_st  = ST_INSERTED;
					state_d = S_IDLE;
				end else if (rd_q.link == NONE) begin
					if (count_q >= NONE) begin
						res_set = 1'b1;
						res_st  = ST_FULL;
						state_d = S_IDLE;
					end else begin
						we        = 1'b1;
						count_inc = 1'b1;
						app_walk  = 1'b1;
						state_d   = S_LINK;
					end
				end else begin
					walk_next = 1'b1;
					state_d   = S_READ;
				end
			end
			S_LINK: begin
				we      = 1'b1;
				waddr   = cur_q[AW-1:0];
				wdata   = '{used: rd_q.used, link: newpos_q, key: rd_q.key, pay: rd_q.pay};
				res_set = 1'b1;
				res_pos = newpos_q;
				res_st  = ST_INSERTED;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q   <= BucketCountReset;
			count_q  <= '0;
			strobe_q <= 1'b0;
			for (int i = 0; i < int'(BUCKETS); i++) begin
				heads_q[i] <= NONE;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				bcnt_q <= cfg_data;
			end
			if (head_we) begin
				heads_q[head_idx] <= head_val;
			end
			if (count_inc) begin
				count_q <= count_q + PW'(1);
			end else if (state_q == S_EXEC && op_q == OP_PRELOAD && slot_ok
				&& count_q < PW'(slot_q) + PW'(1)) begin
				count_q <= PW'(slot_q) + PW'(1);
			end
			strobe_q <= res_set;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			key_q  <= key;
			pay_q  <= payload;
			slot_q <= slot_index;
			bkt_q  <= bucket_index;
			link_q <= link_index;
			occ_q  <= occupied_flag;
		end
		if (state_q == S_HASH && hrsp.done) begin
			cur_q   <= head;
			steps_q <= '0;
		end
		if (walk_next) begin
			cur_q   <= rd_q.link;
			steps_q <= steps_q + PW'(1);
		end
		if (app_walk) begin
			newpos_q <= count_q;
		end
		if (res_set) begin
			pos_q  <= res_pos[7:0];
			stat_q <= res_st;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_q <= mem[cur_q[AW-1:0]];
		end
	end

	assign strobe   = strobe_q;
	assign position = (stat_q == ST_DUPLICATE || stat_q == ST_FULL) ? 8'd0 : pos_q;
	assign status   = stat_q;
endmodule

### src/chti_checker.sv
// Port-level checker for the chained hash table insert block, with its bind.
module chti_port_checks (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic [7:0] position,
	input logic [1:0] status
);
	import chti_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("result strobe held longer than one cycle");

	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(strobe) |-> $past(busy))
		else $error("result without a word in flight");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status == ST_DUPLICATE || status == ST_FULL) |-> position == 8'd0)
		else $error("nonzero position on a failed insert");
endmodule

bind chained_hash_table_insert chti_port_checks u_chti_port_checks (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.strobe   (strobe),
	.position (position),
	.status   (status)
);
